>>> design/assert_macros.svh
// Assertion macros included by the IPv4 header generator design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// Check that a condition never holds at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("forbidden condition seen");

`endif

>>> design/ihg_pkg.sv
// Types and constants of the IPv4 header generator.
package ihg_pkg;

	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned WORD_IDX_W  = 4;
	localparam int unsigned S_TDATA_W   = 56;
	localparam int unsigned M_TDATA_W   = 56;

	localparam logic [15:0] VER_IHL_TOS = 16'h4500;
	localparam logic [15:0] FRAG_WORD   = 16'h0000;
	localparam logic [7:0]  TTL_RESET   = 8'd64;
	localparam logic [15:0] IDENT_RESET = 16'd1;
	localparam logic [31:0] BCAST_ADDR  = 32'hFFFF_FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOCAL   = 2'd0,
		CFG_MASK    = 2'd1,
		CFG_GATEWAY = 2'd2,
		CFG_TTL     = 2'd3
	} cfg_idx_t;

	typedef enum logic [WORD_IDX_W-1:0] {
		W_VER    = 4'd0,
		W_TLEN   = 4'd1,
		W_IDENT  = 4'd2,
		W_FRAG   = 4'd3,
		W_TTL    = 4'd4,
		W_CSUM   = 4'd5,
		W_SRC_HI = 4'd6,
		W_SRC_LO = 4'd7,
		W_DST_HI = 4'd8,
		W_DST_LO = 4'd9
	} word_idx_t;

endpackage

>>> design/ipv4_header_generator.sv
// IPv4 header generator: one send request in, ten header words out.
// Each request beat (destination, protocol, total length) yields ten 16-bit header beats,
// first word first, every beat tagged with its word index, the next-hop address and a
// broadcast flag (tuser); tlast marks the tenth beat. A request passes an input register
// where the checksum and next hop are formed, then loads the output header register once
// that register is free or sending its last beat; the first word is offered from the output
// header register. The 16-bit output channel limits the sustained rate, as each request
// holds it for ten beats; the next request is taken while the current header drains.
// Configuration writes are always ready and must only be issued while no header is pending.
`include "assert_macros.svh"

module ipv4_header_generator (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ihg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                       cfg_data,
	// request stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// dest_address[31:0], protocol_number[39:32], total_length[55:40]
	input  logic [ihg_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	// header word stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// header_word[15:0], word_index[19:16], next_hop[51:20], zero[55:52]
	output logic [ihg_pkg::M_TDATA_W-1:0]     m_axis_tdata,
	output logic                              m_axis_tlast,
	// is_broadcast[0]
	output logic                              m_axis_tuser
);

	// configuration
	logic [31:0] local_addr_q;
	logic [31:0] subnet_mask_q;
	logic [31:0] gateway_q;
	logic [7:0]  ttl_q;
	logic [15:0] ident_q;

	// input register stage
	logic        s1_valid_q;
	logic [31:0] dest_s1;
	logic [7:0]  proto_s1;
	logic [15:0] tlen_s1;
	logic [15:0] ident_s1;

	// output header register
	logic        out_valid_q;
	logic [ihg_pkg::WORD_IDX_W-1:0] cnt_q;
	logic [15:0] tlen_s2;
	logic [15:0] ident_s2;
	logic [15:0] ttlproto_s2;
	logic [15:0] csum_s2;
	logic [31:0] dest_s2;
	logic [31:0] hop_s2;
	logic        bcast_s2;

	logic        s_fire;
	logic        m_fire;
	logic        last_fire;
	logic        s2_load;
	logic [15:0] ttlproto;
	logic [19:0] sum_raw;
	logic [16:0] fold1;
	logic [15:0] fold2;
	logic [31:0] hop;
	logic [15:0] word;

	assign cfg_ready     = 1'b1;
	assign s_fire        = s_axis_tvalid & s_axis_tready;
	assign m_fire        = out_valid_q & m_axis_tready;
	assign last_fire     = m_fire & (cnt_q == ihg_pkg::W_DST_LO);
	assign s2_load       = s1_valid_q & (~out_valid_q | last_fire);
	assign s_axis_tready = ~s1_valid_q | s2_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_addr_q  <= '0;
			subnet_mask_q <= '0;
			gateway_q     <= '0;
			ttl_q         <= ihg_pkg::TTL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ihg_pkg::cfg_idx_t'(cfg_index))
				ihg_pkg::CFG_LOCAL:   local_addr_q  <= cfg_data;
				ihg_pkg::CFG_MASK:    subnet_mask_q <= cfg_data;
				ihg_pkg::CFG_GATEWAY: gateway_q     <= cfg_data;
				ihg_pkg::CFG_TTL:     ttl_q         <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// identification advances once per accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ident_q <= ihg_pkg::IDENT_RESET;
		end else if (s_fire) begin
			ident_q <= ident_q + 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_fire) begin
			s1_valid_q <= 1'b1;
		end else if (s2_load) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			dest_s1  <= s_axis_tdata[31:0];
			proto_s1 <= s_axis_tdata[39:32];
			tlen_s1  <= s_axis_tdata[55:40];
			ident_s1 <= ident_q;
		end
	end

	// one's-complement sum of the header words, checksum word taken as zero
	assign ttlproto = {ttl_q, proto_s1};
	assign sum_raw  = 20'(ihg_pkg::VER_IHL_TOS) + 20'(tlen_s1) + 20'(ident_s1)
		+ 20'(ttlproto) + 20'(local_addr_q[31:16]) + 20'(local_addr_q[15:0])
		+ 20'(dest_s1[31:16]) + 20'(dest_s1[15:0]);
	assign fold1    = 17'(sum_raw[15:0]) + 17'(sum_raw[19:16]);
	assign fold2    = fold1[15:0] + 16'(fold1[16]);

	// route off-subnet traffic through the gateway when one is set
	assign hop = ((gateway_q != 32'd0) &&
		((local_addr_q & subnet_mask_q) != (dest_s1 & subnet_mask_q))) ? gateway_q : dest_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else if (s2_load) begin
			out_valid_q <= 1'b1;
			cnt_q       <= ihg_pkg::W_VER;
		end else if (last_fire) begin
			out_valid_q <= 1'b0;
		end else if (m_fire) begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			tlen_s2     <= tlen_s1;
			ident_s2    <= ident_s1;
			ttlproto_s2 <= ttlproto;
			csum_s2     <= ~fold2;
			dest_s2     <= dest_s1;
			hop_s2      <= hop;
			bcast_s2    <= (hop == ihg_pkg::BCAST_ADDR);
		end
	end

	always_comb begin
		unique case (ihg_pkg::word_idx_t'(cnt_q))
			ihg_pkg::W_VER:    word = ihg_pkg::VER_IHL_TOS;
			ihg_pkg::W_TLEN:   word = tlen_s2;
			ihg_pkg::W_IDENT:  word = ident_s2;
			ihg_pkg::W_FRAG:   word = ihg_pkg::FRAG_WORD;
			ihg_pkg::W_TTL:    word = ttlproto_s2;
			ihg_pkg::W_CSUM:   word = csum_s2;
			ihg_pkg::W_SRC_HI: word = local_addr_q[31:16];
			ihg_pkg::W_SRC_LO: word = local_addr_q[15:0];
			ihg_pkg::W_DST_HI: word = dest_s2[31:16];
			ihg_pkg::W_DST_LO: word = dest_s2[15:0];
			default:           word = '0;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, hop_s2, cnt_q, word};
	assign m_axis_tlast  = (cnt_q == ihg_pkg::W_DST_LO);
	assign m_axis_tuser  = bcast_s2;

	`ASSERT_CLK(a_cnt_range, clk, arst_n, !out_valid_q || cnt_q <= ihg_pkg::W_DST_LO)
	`ASSERT_CLK(a_ident_step, clk, arst_n, s_fire |=> ident_q == $past(ident_q) + 16'd1)
	`ASSERT_CLK(a_drain_idle, clk, arst_n, (last_fire && !s1_valid_q) |=> !m_axis_tvalid)
	`ASSERT_NEVER(a_load_busy, clk, arst_n, s2_load && out_valid_q && !last_fire)

endmodule

>>> bench/ipv4_header_generator_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the IPv4 header generator: request beats in, header beats checked.
module ipv4_header_generator_tb;

	localparam int unsigned HDR_WORDS    = 10;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned MAX_REPORTS  = 10;
	localparam int unsigned BURST_ITEMS  = 16;
	localparam int unsigned PHASE_ITEMS  = 40;
	localparam logic [7:0]  PROTO_ICMP   = 8'd1;
	localparam logic [7:0]  PROTO_TCP    = 8'd6;
	localparam logic [7:0]  PROTO_UDP    = 8'd17;

	// laid out exactly as s_axis_tdata: dest in the low bits
	typedef struct packed {
		logic [15:0] tlen;
		logic [7:0]  proto;
		logic [31:0] dest;
	} send_req_t;

	typedef struct {
		logic [15:0]        word;
		ihg_pkg::word_idx_t idx;
		logic               last;
		logic [31:0]        hop;
		logic               bcast;
	} hdr_beat_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [ihg_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [31:0]                     cfg_data = '0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [ihg_pkg::S_TDATA_W-1:0]   s_axis_tdata = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [ihg_pkg::M_TDATA_W-1:0]   m_axis_tdata;
	logic                            m_axis_tlast;
	logic                            m_axis_tuser;

	// predicted block state
	logic [31:0] local_addr = '0;
	logic [31:0] net_mask = '0;
	logic [31:0] gw_addr = '0;
	logic [7:0]  ttl_val = ihg_pkg::TTL_RESET;
	logic [15:0] next_ident = ihg_pkg::IDENT_RESET;

	send_req_t   req_q[$];
	hdr_beat_t   hdr_q[$];
	int unsigned n_queued = 0;
	int unsigned n_taken = 0;
	int unsigned n_fail = 0;
	bit          no_idle = 1'b0;
	logic        req_taken = 1'b0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned hold_req = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_cnt = 0;

	ipv4_header_generator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// mostly no gap, sometimes a short one, rarely a long one
	function automatic int unsigned pick_idle();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// build the ten header beats for one accepted request
	function automatic void queue_header(send_req_t rq);
		logic [15:0] w [HDR_WORDS];
		logic [31:0] sum;
		logic [31:0] hop;
		hdr_beat_t   b;
		w[0] = ihg_pkg::VER_IHL_TOS;
		w[1] = rq.tlen;
		w[2] = next_ident;
		w[3] = ihg_pkg::FRAG_WORD;
		w[4] = {ttl_val, rq.proto};
		w[5] = 16'h0000;
		w[6] = local_addr[31:16];
		w[7] = local_addr[15:0];
		w[8] = rq.dest[31:16];
		w[9] = rq.dest[15:0];
		sum = '0;
		for (int k = 0; k < HDR_WORDS; k++) begin
			sum = sum + w[k];
			sum = {16'h0000, sum[15:0]} + (sum >> 16);
		end
		w[5] = ~sum[15:0];
		next_ident = next_ident + 16'd1;
		hop = rq.dest;
		if (gw_addr != '0 && (local_addr & net_mask) != (rq.dest & net_mask))
			hop = gw_addr;
		for (int k = 0; k < HDR_WORDS; k++) begin
			b.word = w[k];
			b.idx = ihg_pkg::word_idx_t'(k);
			b.last = (b.idx == ihg_pkg::W_DST_LO);
			b.hop = hop;
			b.bcast = (hop == ihg_pkg::BCAST_ADDR);
			hdr_q.push_back(b);
		end
	endfunction

	function automatic void push_req(send_req_t rq);
		req_q.push_back(rq);
		n_queued++;
	endfunction

	function automatic void send(logic [31:0] dest, logic [7:0] proto, logic [15:0] tlen);
		send_req_t rq;
		rq.dest = dest;
		rq.proto = proto;
		rq.tlen = tlen;
		push_req(rq);
	endfunction

	function automatic send_req_t random_request();
		send_req_t   rq;
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			rq.dest = ihg_pkg::BCAST_ADDR;
		else if (r < 5)
			rq.dest = (local_addr & net_mask) | ($urandom & ~net_mask);
		else
			rq.dest = $urandom;
		case ($urandom_range(0, 9))
			0: rq.proto = PROTO_ICMP;
			1: rq.proto = PROTO_TCP;
			2: rq.proto = PROTO_UDP;
			default: rq.proto = 8'($urandom_range(0, 255));
		endcase
		r = $urandom_range(0, 19);
		if (r == 0)
			rq.tlen = 16'($urandom_range(0, 19));
		else if (r == 1)
			rq.tlen = 16'hFFFF;
		else
			rq.tlen = 16'($urandom_range(20, 65535));
		return rq;
	endfunction

	task automatic write_reg(ihg_pkg::cfg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			ihg_pkg::CFG_LOCAL:   local_addr = val;
			ihg_pkg::CFG_MASK:    net_mask = val;
			ihg_pkg::CFG_GATEWAY: gw_addr = val;
			ihg_pkg::CFG_TTL:     ttl_val = val[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_config();
		int unsigned plen;
		logic [31:0] gw;
		plen = $urandom_range(0, 32);
		case ($urandom_range(0, 7))
			0, 1: gw = '0;
			2: gw = ihg_pkg::BCAST_ADDR;
			default: gw = $urandom;
		endcase
		write_reg(ihg_pkg::CFG_LOCAL, $urandom);
		write_reg(ihg_pkg::CFG_MASK, (plen == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - plen)));
		write_reg(ihg_pkg::CFG_GATEWAY, gw);
		write_reg(ihg_pkg::CFG_TTL, $urandom_range(0, 255));
	endtask

	task automatic wait_idle();
		while (n_taken != n_queued || hdr_q.size() != 0)
			@(posedge clk);
	endtask

	always @(negedge clk) begin : req_driver
		send_req_t rq;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || req_taken) begin
			if (gap_left != 0) begin
				gap_left = gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (req_q.size() != 0) begin
				rq = req_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= rq;
				gap_left = pick_idle();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// long hold-off on the header side, started on request
	always @(negedge clk) begin : hold_timer
		if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_cnt <= HOLD_CYCLES;
		end
	end

	always @(negedge clk) begin : hdr_sink
		if (!arst_n || hold_cnt != 0) begin
			m_axis_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left = stall_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			stall_left = pick_idle();
		end
	end

	always @(posedge clk) begin : beat_check
		hdr_beat_t exp_b;
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready) begin
				queue_header(send_req_t'(s_axis_tdata));
				n_taken++;
			end
			// tdata: word [15:0], index [19:16], next hop [51:20]
			if (m_axis_tvalid && m_axis_tready) begin
				if (hdr_q.size() == 0) begin
					if (n_fail < MAX_REPORTS)
						$display("header beat with no request pending: %h last %b bcast %b",
							m_axis_tdata, m_axis_tlast, m_axis_tuser);
					n_fail++;
				end else begin
					exp_b = hdr_q.pop_front();
					if (m_axis_tdata[15:0] !== exp_b.word || m_axis_tdata[19:16] !== exp_b.idx ||
					    m_axis_tdata[51:20] !== exp_b.hop || m_axis_tlast !== exp_b.last ||
					    m_axis_tuser !== exp_b.bcast) begin
						if (n_fail < MAX_REPORTS)
							$display({"header mismatch: expected word %h idx %0d hop %h last %b ",
								"bcast %b, got word %h idx %0d hop %h last %b bcast %b"},
								exp_b.word, exp_b.idx, exp_b.hop, exp_b.last, exp_b.bcast,
								m_axis_tdata[15:0], m_axis_tdata[19:16], m_axis_tdata[51:20],
								m_axis_tlast, m_axis_tuser);
						n_fail++;
					end
				end
			end
		end
	end

	initial begin : stimulus
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: no gateway, zero mask, default TTL
		send(32'h0000_0000, 8'h00, 16'h0000);
		send(32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
		send(32'hC0A8_0105, PROTO_ICMP, 16'd20);
		send(32'h0A00_0001, PROTO_TCP, 16'd19);
		send(32'h0808_0808, PROTO_UDP, 16'd1500);
		wait_idle();

		write_reg(ihg_pkg::CFG_LOCAL, 32'hC0A8_010A);
		write_reg(ihg_pkg::CFG_MASK, 32'hFFFF_FF00);
		write_reg(ihg_pkg::CFG_GATEWAY, 32'hC0A8_0101);
		write_reg(ihg_pkg::CFG_TTL, 32'd255);
		send(32'hC0A8_0114, PROTO_TCP, 16'd60);
		send(32'h0808_0808, PROTO_UDP, 16'd576);
		send(32'hFFFF_FFFF, PROTO_ICMP, 16'd84);
		send(32'hC0A8_01FF, PROTO_UDP, 16'd28);
		wait_idle();

		// zero mask: everything is local, hop stays the destination
		write_reg(ihg_pkg::CFG_LOCAL, 32'hFFFF_FFFF);
		write_reg(ihg_pkg::CFG_MASK, 32'h0000_0000);
		write_reg(ihg_pkg::CFG_GATEWAY, 32'hFFFF_FFFF);
		write_reg(ihg_pkg::CFG_TTL, 32'd0);
		send(32'h0102_0304, 8'h55, 16'hAAAA);
		send(32'h0000_0000, 8'hAA, 16'h5555);
		wait_idle();

		// full mask: off-subnet goes to an all-ones gateway
		write_reg(ihg_pkg::CFG_MASK, 32'hFFFF_FFFF);
		send(32'h0102_0304, PROTO_TCP, 16'd40);
		send(32'hFFFF_FFFF, PROTO_UDP, 16'd1000);
		send(32'hFFFF_FFFE, PROTO_ICMP, 16'd21);
		wait_idle();

		// back-to-back burst with no idle cycles on either side
		no_idle = 1'b1;
		repeat (BURST_ITEMS) push_req(random_request());
		wait_idle();
		no_idle = 1'b0;

		for (int ph = 0; ph < 3; ph++) begin
			random_config();
			@(posedge clk);
			if (ph == 1)
				hold_req++;
			repeat (PHASE_ITEMS) push_req(random_request());
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_fail == 0)
			$display("ipv4_header_generator verification clean");
		else
			$display("ipv4_header_generator verification failed");
		$finish;
	end

	initial begin : watchdog
		#(64'd50_000_000);
		$display("ipv4_header_generator verification failed");
		$finish;
	end

endmodule
